// ===== hw/rtl/rmq_pkg.sv =====
// Shared constants for the rotation matrix to quaternion converter.
`default_nettype none
package rmq_pkg;
    localparam int FIELD_W       = 18;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_IN          = 9;
    localparam int N_Q           = 4;
    localparam int IN_TDATA_W    = ((N_IN * FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = ((N_Q * FIELD_W + 7) / 8) * 8;
    localparam int OUT_MAX       = 131071;
    localparam int OUT_MIN_MAG   = 131072;
endpackage
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion_top.sv =====
// Pipelined rotation matrix to unit quaternion converter (Shepperd branch choice).
//
//  channel   | dir | tdata (low bit up)                 | tuser
//  s_axis    | in  | m00 m01 m02 m10 m11 m12 m20 m21 m22 | -
//  m_axis    | out | quat_w quat_x quat_y quat_z         | invalid
//
// One item per cycle while m_axis is not stalled. The pipeline has H = MW + 1 square-root
// stages (one result bit each) and Q = FRAC_BITS + 1 divider stages.
// Synchronous active-low reset clears the valid bits only.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
`default_nettype none
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // m00 m01 m02 m10 m11 m12 m20 m21 m22, 18 bits each, zero padded
    input  wire logic [rmq_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // quat_w quat_x quat_y quat_z, 18 bits each
    output logic [rmq_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // invalid
    output logic                                o_m_axis_tuser
);
    localparam int FW  = rmq_pkg::FIELD_W;
    localparam int RW  = (FRAC_BITS > 19 ? FRAC_BITS : 19) + 3;
    localparam int MW  = RW;
    localparam int SW  = 2 * MW + 2;
    localparam int H   = SW / 2;
    localparam int RQ  = H + 3;
    localparam int NW  = MW + FRAC_BITS + 1;
    localparam int Q   = FRAC_BITS + 1;
    localparam int RD  = H + 1;
    localparam int QW  = (Q > FW ? Q : FW) + 1;
    localparam logic signed [RW-1:0] ONE = RW'(64'd1 << FRAC_BITS);

    logic w_en;
    assign w_en            = ~o_m_axis_tvalid | i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // stage 1: branch choice and vector
    logic signed [RW-1:0] w_m [rmq_pkg::N_IN];
    logic signed [RW-1:0] w_tr, w_rad;
    logic signed [RW-1:0] w_v [4];

    always_comb begin
        for (int i = 0; i < rmq_pkg::N_IN; i++) begin
            w_m[i] = RW'($signed(i_s_axis_tdata[i*FW +: FW]));
        end
        w_tr = w_m[0] + w_m[4] + w_m[8];
        if (w_tr > 0) begin
            w_rad  = w_tr + ONE;
            w_v[0] = w_rad;
            w_v[1] = w_m[7] - w_m[5];
            w_v[2] = w_m[2] - w_m[6];
            w_v[3] = w_m[3] - w_m[1];
        end else if (w_m[0] > w_m[4] && w_m[0] > w_m[8]) begin
            w_rad  = ONE + w_m[0] - w_m[4] - w_m[8];
            w_v[0] = w_m[7] - w_m[5];
            w_v[1] = w_rad;
            w_v[2] = w_m[1] + w_m[3];
            w_v[3] = w_m[2] + w_m[6];
        end else if (w_m[4] > w_m[8]) begin
            w_rad  = ONE + w_m[4] - w_m[0] - w_m[8];
            w_v[0] = w_m[2] - w_m[6];
            w_v[1] = w_m[1] + w_m[3];
            w_v[2] = w_rad;
            w_v[3] = w_m[5] + w_m[7];
        end else begin
            w_rad  = ONE + w_m[8] - w_m[0] - w_m[4];
            w_v[0] = w_m[3] - w_m[1];
            w_v[1] = w_m[2] + w_m[6];
            w_v[2] = w_m[5] + w_m[7];
            w_v[3] = w_rad;
        end
    end

    logic                 r_s1_vld, r_s1_bad;
    logic signed [RW-1:0] r_s1_v [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_s_axis_tvalid;
        end
        if (w_en) begin
            r_s1_bad <= (w_rad <= 0);
            for (int i = 0; i < 4; i++) r_s1_v[i] <= w_v[i];
        end
    end

    // stage 2: magnitudes and squares
    logic            r_s2_vld, r_s2_bad;
    logic [3:0]      r_s2_sgn;
    logic [MW-1:0]   r_s2_mag [4];
    logic [2*MW-1:0] r_s2_sq  [4];
    logic [MW-1:0]   w_mag    [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_mag[i] = r_s1_v[i][RW-1] ? MW'(-r_s1_v[i]) : MW'(r_s1_v[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (w_en) begin
            r_s2_bad <= r_s1_bad;
            for (int i = 0; i < 4; i++) begin
                r_s2_sgn[i] <= r_s1_v[i][RW-1];
                r_s2_mag[i] <= w_mag[i];
                r_s2_sq[i]  <= (2*MW)'(w_mag[i]) * (2*MW)'(w_mag[i]);
            end
        end
    end

    // stage 3: sum of squares
    logic          r_s3_vld, r_s3_bad;
    logic [3:0]    r_s3_sgn;
    logic [MW-1:0] r_s3_mag [4];
    logic [SW-1:0] r_s3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s3_vld <= r_s2_vld;
        end
        if (w_en) begin
            r_s3_bad <= r_s2_bad;
            r_s3_sgn <= r_s2_sgn;
            for (int i = 0; i < 4; i++) r_s3_mag[i] <= r_s2_mag[i];
            r_s3_sum <= SW'(r_s2_sq[0]) + SW'(r_s2_sq[1]) + SW'(r_s2_sq[2]) + SW'(r_s2_sq[3]);
        end
    end

    // square root, one result bit per stage
    logic          r_sq_vld  [H];
    logic          r_sq_bad  [H];
    logic [3:0]    r_sq_sgn  [H];
    logic [MW-1:0] r_sq_mag  [H][4];
    logic [SW-1:0] r_sq_sum  [H];
    logic [RQ-1:0] r_sq_rem  [H];
    logic [H-1:0]  r_sq_root [H];

    for (genvar k = 0; k < H; k++) begin : g_sqrt
        logic          w_vld, w_bad;
        logic [3:0]    w_sgn;
        logic [MW-1:0] w_mg [4];
        logic [SW-1:0] w_sum;
        logic [RQ-1:0] w_rem, w_sh, w_trial;
        logic [H-1:0]  w_root;

        if (k == 0) begin : g_first
            always_comb begin
                w_vld  = r_s3_vld;
                w_bad  = r_s3_bad;
                w_sgn  = r_s3_sgn;
                w_sum  = r_s3_sum;
                w_rem  = '0;
                w_root = '0;
                for (int i = 0; i < 4; i++) w_mg[i] = r_s3_mag[i];
            end
        end else begin : g_next
            always_comb begin
                w_vld  = r_sq_vld[k-1];
                w_bad  = r_sq_bad[k-1];
                w_sgn  = r_sq_sgn[k-1];
                w_sum  = r_sq_sum[k-1];
                w_rem  = r_sq_rem[k-1];
                w_root = r_sq_root[k-1];
                for (int i = 0; i < 4; i++) w_mg[i] = r_sq_mag[k-1][i];
            end
        end

        assign w_sh    = {w_rem[RQ-3:0], w_sum[SW-1-2*k -: 2]};
        assign w_trial = {1'b0, w_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k] <= w_vld;
            end
            if (w_en) begin
                r_sq_bad[k] <= w_bad;
                r_sq_sgn[k] <= w_sgn;
                r_sq_sum[k] <= w_sum;
                for (int i = 0; i < 4; i++) r_sq_mag[k][i] <= w_mg[i];
                if (w_sh >= w_trial) begin
                    r_sq_rem[k]  <= w_sh - w_trial;
                    r_sq_root[k] <= {w_root[H-2:0], 1'b1};
                end else begin
                    r_sq_rem[k]  <= w_sh;
                    r_sq_root[k] <= {w_root[H-2:0], 1'b0};
                end
            end
        end
    end

    // numerators with half-norm rounding term
    logic          r_nm_vld, r_nm_bad;
    logic [3:0]    r_nm_sgn;
    logic [H-1:0]  r_nm_n;
    logic [NW-1:0] r_nm_num [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nm_vld <= 1'b0;
        end else if (w_en) begin
            r_nm_vld <= r_sq_vld[H-1];
        end
        if (w_en) begin
            r_nm_bad <= r_sq_bad[H-1] | (r_sq_root[H-1] == '0);
            r_nm_sgn <= r_sq_sgn[H-1];
            r_nm_n   <= r_sq_root[H-1];
            for (int i = 0; i < 4; i++) begin
                r_nm_num[i] <= (NW'(r_sq_mag[H-1][i]) << FRAC_BITS)
                             + NW'(r_sq_root[H-1] >> 1);
            end
        end
    end

    // restoring division, one quotient bit per stage, four lanes
    logic          r_dv_vld [Q];
    logic          r_dv_bad [Q];
    logic [3:0]    r_dv_sgn [Q];
    logic [H-1:0]  r_dv_n   [Q];
    logic [NW-1:0] r_dv_num [Q][4];
    logic [RD-1:0] r_dv_rem [Q][4];
    logic [Q-1:0]  r_dv_quo [Q][4];

    for (genvar j = 0; j < Q; j++) begin : g_div
        logic          w_vld, w_bad;
        logic [3:0]    w_sgn;
        logic [H-1:0]  w_n;
        logic [NW-1:0] w_num [4];
        logic [RD-1:0] w_rem [4];
        logic [Q-1:0]  w_quo [4];
        logic [RD:0]   w_t   [4];

        if (j == 0) begin : g_first
            always_comb begin
                w_vld = r_nm_vld;
                w_bad = r_nm_bad;
                w_sgn = r_nm_sgn;
                w_n   = r_nm_n;
                for (int i = 0; i < 4; i++) begin
                    w_num[i] = r_nm_num[i];
                    w_rem[i] = RD'(r_nm_num[i] >> Q);
                    w_quo[i] = '0;
                end
            end
        end else begin : g_next
            always_comb begin
                w_vld = r_dv_vld[j-1];
                w_bad = r_dv_bad[j-1];
                w_sgn = r_dv_sgn[j-1];
                w_n   = r_dv_n[j-1];
                for (int i = 0; i < 4; i++) begin
                    w_num[i] = r_dv_num[j-1][i];
                    w_rem[i] = r_dv_rem[j-1][i];
                    w_quo[i] = r_dv_quo[j-1][i];
                end
            end
        end

        always_comb begin
            for (int i = 0; i < 4; i++) w_t[i] = {w_rem[i], w_num[i][Q-1-j]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[j] <= w_vld;
            end
            if (w_en) begin
                r_dv_bad[j] <= w_bad;
                r_dv_sgn[j] <= w_sgn;
                r_dv_n[j]   <= w_n;
                for (int i = 0; i < 4; i++) begin
                    r_dv_num[j][i] <= w_num[i];
                    if (w_t[i] >= (RD+1)'(w_n)) begin
                        r_dv_rem[j][i] <= RD'(w_t[i] - (RD+1)'(w_n));
                        r_dv_quo[j][i] <= {w_quo[i][Q-2:0], 1'b1};
                    end else begin
                        r_dv_rem[j][i] <= RD'(w_t[i]);
                        r_dv_quo[j][i] <= {w_quo[i][Q-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // sign, saturation, output register
    logic [QW-1:0]        w_qc [4];
    logic signed [QW:0]   w_qs [4];
    logic [FW-1:0]        w_qo [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_qc[i] = (QW'(r_dv_quo[Q-1][i]) > QW'(rmq_pkg::OUT_MIN_MAG))
                    ? QW'(rmq_pkg::OUT_MIN_MAG) : QW'(r_dv_quo[Q-1][i]);
            w_qs[i] = r_dv_sgn[Q-1][i] ? -$signed({1'b0, w_qc[i]}) : $signed({1'b0, w_qc[i]});
            if (r_dv_bad[Q-1]) begin
                w_qo[i] = '0;
            end else if (w_qs[i] > $signed((QW+1)'(rmq_pkg::OUT_MAX))) begin
                w_qo[i] = FW'(rmq_pkg::OUT_MAX);
            end else begin
                w_qo[i] = FW'(w_qs[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_axis_tvalid <= 1'b0;
        end else if (w_en) begin
            o_m_axis_tvalid <= r_dv_vld[Q-1];
        end
        if (w_en) begin
            o_m_axis_tdata <= rmq_pkg::OUT_TDATA_W'({w_qo[3], w_qo[2], w_qo[1], w_qo[0]});
            o_m_axis_tuser <= r_dv_bad[Q-1];
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_checker.sv =====
// Port-level checks for the quaternion converter, bound to the top level.
`default_nettype none
module rmq_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_s_axis_tready,
    input wire logic                           o_m_axis_tvalid,
    input wire logic                           i_m_axis_tready,
    input wire logic [rmq_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic                           o_m_axis_tuser
);
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("invalid item with nonzero quaternion");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("item shown straight after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output stage");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled output item changed");
endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
`default_nettype wire

// ===== tb/rotation_matrix_to_quaternion_top_tb.sv =====
// Testbench for the rotation matrix to quaternion converter: random and directed matrices.
`timescale 1ns / 100ps
`default_nettype none
module rotation_matrix_to_quaternion_top_tb;
    localparam int FB = rmq_pkg::FRAC_BITS_DEF;
    localparam int FW = rmq_pkg::FIELD_W;

    typedef logic signed [FW-1:0] t_elem;
    typedef struct packed {
        logic          bad;
        t_elem [3:0]   q;
    } t_quat;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rmq_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rmq_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                             m_tuser;

    logic [rmq_pkg::IN_TDATA_W-1:0]   matrix_q[$];
    t_quat                            quat_exp_q[$];
    int                               n_fail = 0;
    bit                               stim_done = 1'b0;
    int                               send_gap = 0;
    int                               recv_gap = 0;
    int                               hold_off = 0;
    int                               n_recv = 0;

    rotation_matrix_to_quaternion_top #(.FRAC_BITS(FB)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_quat matrix_to_quat(logic [rmq_pkg::IN_TDATA_W-1:0] d);
        longint m[9];
        longint v[4];
        longint one, tr, rad, q;
        longint unsigned a, sum, nrm, qm;
        t_quat r;
        one = longint'(1) << FB;
        for (int i = 0; i < 9; i++) m[i] = longint'(t_elem'(d[i*FW +: FW]));
        tr = m[0] + m[4] + m[8];
        if (tr > 0) begin
            rad = tr + one;
            v = '{rad, m[7] - m[5], m[2] - m[6], m[3] - m[1]};
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            rad = one + m[0] - m[4] - m[8];
            v = '{m[7] - m[5], rad, m[1] + m[3], m[2] + m[6]};
        end else if (m[4] > m[8]) begin
            rad = one + m[4] - m[0] - m[8];
            v = '{m[2] - m[6], m[1] + m[3], rad, m[5] + m[7]};
        end else begin
            rad = one + m[8] - m[0] - m[4];
            v = '{m[3] - m[1], m[2] + m[6], m[5] + m[7], rad};
        end
        r = '0;
        r.bad = rad <= 0;
        nrm = 0;
        if (!r.bad) begin
            sum = 0;
            for (int i = 0; i < 4; i++) begin
                a = v[i] < 0 ? -v[i] : v[i];
                sum += a * a;
            end
            nrm = int_sqrt(sum);
            if (nrm == 0) r.bad = 1'b1;
        end
        if (!r.bad) begin
            for (int i = 0; i < 4; i++) begin
                a = v[i] < 0 ? -v[i] : v[i];
                qm = ((a << FB) + (nrm >> 1)) / nrm;
                if (qm > rmq_pkg::OUT_MIN_MAG) qm = rmq_pkg::OUT_MIN_MAG;
                q = v[i] < 0 ? -longint'(qm) : longint'(qm);
                if (q > rmq_pkg::OUT_MAX) q = rmq_pkg::OUT_MAX;
                r.q[i] = t_elem'(q);
            end
        end
        return r;
    endfunction

    function automatic logic [rmq_pkg::IN_TDATA_W-1:0] pack_matrix(longint e[9]);
        logic [rmq_pkg::IN_TDATA_W-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++) d[i*FW +: FW] = t_elem'(e[i]);
        return d;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint rnd_elem(int mode);
        case (mode)
            0: return longint'($urandom_range(0, 262143)) - 131072;
            1: return longint'($urandom_range(0, 131072)) - 65536;
            2: return ($urandom_range(0, 1) ? 131071 : -131072);
            default: return longint'($urandom_range(0, 8)) - 4;
        endcase
    endfunction

    // directed and random matrices
    initial begin
        longint e[9];
        longint c, s;
        int mode;
        for (int k = 0; k < 24; k++) begin
            for (int i = 0; i < 9; i++) e[i] = 0;
            case (k)
                0: ;
                1: begin e[0] = 65536; e[4] = 65536; e[8] = 65536; end
                2: begin e[0] = 65536; e[4] = -65536; e[8] = -65536; end
                3: begin e[0] = -65536; e[4] = 65536; e[8] = -65536; end
                4: begin e[0] = -65536; e[4] = -65536; e[8] = 65536; end
                5: for (int i = 0; i < 9; i++) e[i] = 131071;
                6: for (int i = 0; i < 9; i++) e[i] = -131072;
                7: for (int i = 0; i < 9; i++) e[i] = (i % 2) ? 131071 : -131072;
                8: for (int i = 0; i < 9; i++) e[i] = (i % 2) ? -131072 : 131071;
                9: begin e[0] = -131072; e[4] = -131072; e[8] = -131072; end
                10: begin e[0] = -65536; e[4] = -65536; e[8] = -65536; end
                11: begin e[0] = 1; end
                12: begin e[0] = -65536; e[4] = 0; e[8] = 0; e[1] = 131071; end
                13: begin e[0] = 0; e[4] = 0; e[8] = 0; e[7] = 131071; e[5] = -131072; end
                14: begin e[0] = 131071; e[4] = 131071; e[8] = 131071; end
                15: begin e[0] = -40000; e[4] = -40000; e[8] = -40000; end
                16: begin e[0] = 100; e[4] = 100; e[8] = -65536; end
                17: begin e[4] = 5; e[8] = 5; e[0] = -10; end
                default: begin
                    c = longint'($urandom_range(0, 131072)) - 65536;
                    s = longint'($urandom_range(0, 131072)) - 65536;
                    e[0] = c; e[1] = -s; e[3] = s; e[4] = c; e[8] = 65536;
                    if (k % 3 == 1) begin e[0] = -65536; e[8] = -c; e[1] = 0; e[3] = 0;
                        e[5] = -s; e[7] = s; e[4] = c; end
                end
            endcase
            matrix_q.insert(matrix_q.size(), pack_matrix(e));
        end
        for (int k = 0; k < 1250; k++) begin
            mode = $urandom_range(0, 9);
            for (int i = 0; i < 9; i++)
                e[i] = rnd_elem(mode < 6 ? 0 : mode < 8 ? 1 : mode < 9 ? 2 : 3);
            matrix_q.insert(matrix_q.size(), pack_matrix(e));
        end
        stim_done = 1'b1;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // sender
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                quat_exp_q.insert(quat_exp_q.size(), matrix_to_quat(s_tdata));
                send_gap = pick_gap();
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (matrix_q.size() > 0) begin
                    s_tdata <= matrix_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver with one long hold-off to fill the pipeline
    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                got.q = m_tdata[rmq_pkg::N_Q*FW-1:0];
                got.bad = m_tuser;
                n_recv++;
                if (quat_exp_q.size() == 0) begin
                    $display("%0t: unexpected item q=%h bad=%b", $time, got.q, got.bad);
                    n_fail++;
                end else begin
                    want = quat_exp_q.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (got.q[i] !== want.q[i]) begin
                            $display("%0t: q%0d expected %0d actual %0d", $time, i,
                                     want.q[i], got.q[i]);
                            n_fail++;
                        end
                    if (got.bad !== want.bad) begin
                        $display("%0t: invalid expected %b actual %b", $time,
                                 want.bad, got.bad);
                        n_fail++;
                    end
                end
                if (n_recv == 100) hold_off = 300;
            end
            if (hold_off > 0) begin
                hold_off--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    initial begin
        wait (stim_done && i_rst_n);
        wait (matrix_q.size() == 0 && !s_tvalid && quat_exp_q.size() == 0);
        repeat (100) @(posedge i_clk);
        if (n_fail == 0 && quat_exp_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire
